### rtl/core/byte_tone_synthesizer_macros.svh
// Assertion macros for the tone synthesizer checker
`ifndef BYTE_TONE_SYNTHESIZER_MACROS_SVH
`define BYTE_TONE_SYNTHESIZER_MACROS_SVH

// same-cycle implication, off during reset
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// state in the cycle after a reset cycle
`define BTS_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### rtl/core/bts_pkg.sv
package bts_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_CFG_W   = 16;
  localparam int AMP_W       = 16;
  localparam int SAMPLE_W    = 16;
  localparam int SINE_MAG_W  = 15;
  localparam int MAG_PROD_W  = AMP_W + SINE_MAG_W;
  localparam int STEP_PROD_W = CFG_DATA_W + BYTE_W;
  localparam int TREE_W      = STEP_PROD_W + 2;
  localparam int FIX_W       = 10;

  localparam int FULL_SCALE       = 32767;
  localparam int FULL_SCALE_SHIFT = 15;
  localparam int BYTE_MAX         = 255;
  localparam int AMP_BASE         = 3277;
  localparam int AMP_SPAN         = 29490;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BASE_STEP_RST   = 32'd21426141;
  localparam logic [CFG_DATA_W-1:0] RANGE_STEP_RST  = 32'd194783096;
  localparam logic [LEN_CFG_W-1:0]  NOTE_LENGTH_RST = 16'd2205;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio_sample;
    logic                       last_of_note;
  } out_item_t;

  typedef struct packed {
    logic             neg;
    logic             last;
    logic [AMP_W-1:0] amp;
  } tick_ctl_t;

  function automatic logic [AMP_W-1:0] amp_of(input int unsigned b);
    return AMP_W'(AMP_BASE + (AMP_SPAN * b) / BYTE_MAX);
  endfunction

  // sin(pi/2 * k / 2^qbits) * 32767 from a Q30 Taylor series, rounded and capped
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned k,
                                                         input int unsigned qbits);
    longint unsigned x;
    longint unsigned sum;
    longint unsigned t;
    longint unsigned v;
    x = (HALF_PI_Q30 * 64'(k)) >> qbits;
    sum = x;
    t = x;
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (n)
        1: t = t / 6;
        2: t = t / 20;
        3: t = t / 42;
        4: t = t / 72;
        5: t = t / 110;
        6: t = t / 156;
        default: t = t / 210;
      endcase
      if (n[0]) begin
        sum = (t > sum) ? 64'd0 : sum - t;
      end else begin
        sum = sum + t;
      end
    end
    v = (sum * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (v > 64'(FULL_SCALE)) begin
      v = 64'(FULL_SCALE);
    end
    return SINE_MAG_W'(v);
  endfunction

endpackage

### rtl/core/byte_tone_synthesizer.sv
// Throughput: one item per cycle unless out_stall backs up the pipe; a load is seen by a tick in the next cycle.
// Path: input register, note state and phase adder, quarter-wave ROM read,
//   amplitude multiply, divide by full scale into the output register.
// Reset (rst_n low, synchronous): registers back to defaults, no note armed, pipe empty.
module byte_tone_synthesizer #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int LENGTH_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bts_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bts_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bts_pkg::*;

  localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;

  logic [CFG_DATA_W-1:0] base_step_r;
  logic [CFG_DATA_W-1:0] range_step_r;
  logic [LEN_CFG_W-1:0]  note_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r   <= BASE_STEP_RST;
      range_step_r  <= RANGE_STEP_RST;
      note_length_r <= NOTE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_STEP:   base_step_r   <= cfg_wdata;
        REG_RANGE_STEP:  range_step_r  <= cfg_wdata;
        REG_NOTE_LENGTH: note_length_r <= cfg_wdata[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [AMP_W-1:0] amp_tab [1 << BYTE_W];

  for (genvar b = 0; b < (1 << BYTE_W); b++) begin : g_amp
    localparam logic [AMP_W-1:0] VAL = amp_of(b);
    assign amp_tab[b] = VAL;
  end

  logic                   s1_v_r;
  in_item_t               s1_item_r;
  logic [STEP_PROD_W-1:0] s1_mult_r;
  logic                   s1_ready;
  logic                   s1_emit;
  logic                   s1_fire;
  logic                   in_xfer;

  logic                   s2_v_r;
  tick_ctl_t              s2_ctl_r;
  logic                   s2_ready;
  logic                   s3_v_r;
  tick_ctl_t              s3_ctl_r;
  logic [MAG_PROD_W-1:0]  s3_prod_r;
  logic                   s3_ready;
  logic                   s4_ready;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [PHASE_BITS-1:0]  phase_r,     phase_nxt;
  logic [PHASE_BITS-1:0]  step_est_r,  step_est_nxt;
  logic [FIX_W-1:0]       v_lo_r,      v_lo_nxt;
  logic [FIX_W-1:0]       base_lo_r,   base_lo_nxt;
  logic [AMP_W-1:0]       amp_r,       amp_nxt;
  logic [LENGTH_BITS-1:0] left_r,      left_nxt;
  logic                   active_r,    active_nxt;

  logic [TREE_W-1:0]          step_sum;
  logic [FIX_W-1:0]           qe_lo;
  logic [FIX_W-1:0]           rem_lo;
  logic                       step_fix;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [QUARTER_BITS-1:0]    quad_off;
  logic [QUARTER_BITS:0]      rom_addr;
  logic [SINE_MAG_W-1:0]      rom_data;
  logic [MAG_PROD_W-1:0]      q_sum;
  logic [SAMPLE_W-1:0]        q_mag;

  assign s4_ready = !out_valid_r || !out_stall;
  assign s3_ready = !s3_v_r || s4_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_emit  = s1_v_r && (s1_item_r.command == CMD_TICK) && active_r;
  assign s1_fire  = s1_v_r && (!s1_emit || s2_ready);
  assign s1_ready = !s1_v_r || s1_fire;
  assign in_stall = !s1_ready;
  assign in_xfer  = in_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
      s1_mult_r <= STEP_PROD_W'(range_step_r) * STEP_PROD_W'(in_data.data_byte);
    end
  end

  // floor(v/255) from the base-256 digit sum, short by at most one; the
  // shortfall is resolved per tick as a carry into the phase adder
  always_comb begin
    step_sum = TREE_W'(s1_mult_r)
             + TREE_W'(s1_mult_r >> BYTE_W)
             + TREE_W'(s1_mult_r >> (2 * BYTE_W))
             + TREE_W'(s1_mult_r >> (3 * BYTE_W))
             + TREE_W'(s1_mult_r >> (4 * BYTE_W))
             + (TREE_W'(base_step_r) << BYTE_W);
    qe_lo    = step_est_r[FIX_W-1:0] - base_lo_r;
    rem_lo   = v_lo_r - ((qe_lo << BYTE_W) - qe_lo);
    step_fix = (rem_lo >= FIX_W'(BYTE_MAX));
  end

  always_comb begin
    tab_idx  = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad_off = tab_idx[QUARTER_BITS-1:0];
    if (tab_idx[QUARTER_BITS]) begin
      rom_addr = (QUARTER_BITS + 1)'(QUARTER) - {1'b0, quad_off};
    end else begin
      rom_addr = {1'b0, quad_off};
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    step_est_nxt = step_est_r;
    v_lo_nxt     = v_lo_r;
    base_lo_nxt  = base_lo_r;
    amp_nxt      = amp_r;
    left_nxt     = left_r;
    active_nxt   = active_r;
    if (s1_fire) begin
      if (s1_item_r.command == CMD_LOAD) begin
        phase_nxt    = '0;
        step_est_nxt = PHASE_BITS'(step_sum >> BYTE_W);
        v_lo_nxt     = s1_mult_r[FIX_W-1:0];
        base_lo_nxt  = base_step_r[FIX_W-1:0];
        amp_nxt      = amp_tab[s1_item_r.data_byte];
        left_nxt     = LENGTH_BITS'(note_length_r);
        active_nxt   = (LENGTH_BITS'(note_length_r) != '0);
      end else if (s1_emit) begin
        phase_nxt    = phase_r + step_est_r + PHASE_BITS'(step_fix);
        left_nxt     = left_r - LENGTH_BITS'(1);
        active_nxt   = (left_r != LENGTH_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      step_est_r <= '0;
      amp_r      <= '0;
      left_r     <= '0;
      active_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      step_est_r <= step_est_nxt;
      amp_r      <= amp_nxt;
      left_r     <= left_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_lo_r    <= v_lo_nxt;
    base_lo_r <= base_lo_nxt;
  end

  bts_sine_rom #(
    .QUARTER_BITS (QUARTER_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (s1_emit && s1_fire),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_emit && s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit && s1_fire) begin
      s2_ctl_r.neg  <= tab_idx[SINE_TABLE_BITS-1];
      s2_ctl_r.last <= (left_r == LENGTH_BITS'(1));
      s2_ctl_r.amp  <= amp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_ready) begin
      s3_ctl_r  <= s2_ctl_r;
      s3_prod_r <= MAG_PROD_W'(s2_ctl_r.amp) * MAG_PROD_W'(rom_data);
    end
  end

  // divide by 2^15-1: exact for products up to full scale squared
  always_comb begin
    q_sum = s3_prod_r + (s3_prod_r >> FULL_SCALE_SHIFT) + MAG_PROD_W'(1);
    q_mag = SAMPLE_W'(q_sum >> FULL_SCALE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s4_ready) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && s4_ready) begin
      out_data_r.audio_sample <= s3_ctl_r.neg ? $signed(-q_mag) : $signed(q_mag);
      out_data_r.last_of_note <= s3_ctl_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/bts_sine_rom.sv
module bts_sine_rom #(
  parameter int QUARTER_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [QUARTER_BITS:0]               rd_addr,
  output logic [bts_pkg::SINE_MAG_W-1:0]      rd_data
);
  import bts_pkg::*;

  localparam int QUARTER = 1 << QUARTER_BITS;

  logic [SINE_MAG_W-1:0] qrom [QUARTER+1];
  logic [SINE_MAG_W-1:0] rd_data_r;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_qrom
    localparam logic [SINE_MAG_W-1:0] VAL = quarter_sine(k, QUARTER_BITS);
    assign qrom[k] = VAL;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= qrom[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/bts_checker.sv
`include "byte_tone_synthesizer_macros.svh"

module bts_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bts_pkg::out_item_t out_data
);

  logic in_xfer;

  assign in_xfer = in_valid && !in_stall;

  `BTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed or dropped")
  `BTS_ASSERT_RESET(a_reset_empty, !out_valid, "result shown right after reset")
  `BTS_ASSERT_NOW(a_empty_takes_input, !out_valid, !in_stall, "input stalled with empty output")
  `BTS_ASSERT_NEXT(a_drained_stays_empty, !out_valid && !$past(out_valid, 1) && !$past(out_valid, 2) && !$past(out_valid, 3) && !$past(in_xfer, 3), !out_valid, "result without a transfer in flight")

endmodule

bind byte_tone_synthesizer bts_checker u_bts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sv/byte_tone_synthesizer_tb.sv
module byte_tone_synthesizer_tb;
  import bts_pkg::*;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int LENGTH_BITS     = 16;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int QUARTER         = TABLE_SIZE / 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SQUEEZE_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  class tone_scoreboard;
    logic [31:0]        base_step;
    logic [31:0]        range_step;
    logic [15:0]        note_length;
    logic [31:0]        phase;
    logic [31:0]        note_step;
    logic [15:0]        amplitude;
    logic [15:0]        samples_left;
    bit                 note_active;
    logic signed [15:0] sine_lut [TABLE_SIZE];
    out_item_t          pending_samples [$];
    int unsigned        errors;
    int unsigned        loads;
    int unsigned        ticks;
    int unsigned        compared;
    int unsigned        note_ends;

    function new();
      int unsigned quad;
      int unsigned j;
      int          s;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        quad = i / QUARTER;
        j    = i % QUARTER;
        s    = quad[0] ? quarter_wave_q15(QUARTER - j) : quarter_wave_q15(j);
        sine_lut[i] = quad[1] ? 16'(-s) : 16'(s);
      end
      base_step    = BASE_STEP_RST;
      range_step   = RANGE_STEP_RST;
      note_length  = NOTE_LENGTH_RST;
      phase        = '0;
      note_step    = '0;
      amplitude    = '0;
      samples_left = '0;
      note_active  = 1'b0;
    endfunction

    function int quarter_wave_q15(int unsigned k);
      longint unsigned x;
      longint unsigned acc;
      longint unsigned term;
      longint unsigned v;
      x    = (HALF_PI_Q30 * longint'(k)) / QUARTER;
      acc  = x;
      term = x;
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = (term > acc) ? 64'd0 : acc - term;
        end else begin
          acc = acc + term;
        end
      end
      v = (acc * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(FULL_SCALE)) begin
        v = 64'(FULL_SCALE);
      end
      return int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BASE_STEP: begin
          base_step = val;
        end
        REG_RANGE_STEP: begin
          range_step = val;
        end
        REG_NOTE_LENGTH: begin
          note_length = val[15:0];
        end
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      longint unsigned step_sum;
      int              prod;
      int              mag;
      out_item_t       want;
      if (it.command == CMD_LOAD) begin
        loads++;
        step_sum     = longint'(base_step) + (longint'(range_step) * it.data_byte) / BYTE_MAX;
        note_step    = step_sum[31:0];
        amplitude    = 16'(AMP_BASE + (AMP_SPAN * int'(it.data_byte)) / BYTE_MAX);
        phase        = '0;
        samples_left = note_length;
        note_active  = (note_length != 0);
      end else begin
        ticks++;
        if (note_active) begin
          prod = int'(amplitude) * int'(sine_lut[phase[PHASE_BITS-1 -: SINE_TABLE_BITS]]);
          mag  = ((prod < 0) ? -prod : prod) / FULL_SCALE;
          want.audio_sample = 16'((prod < 0) ? -mag : mag);
          want.last_of_note = (samples_left == 16'd1);
          pending_samples.push_back(want);
          phase        = phase + note_step;
          samples_left = samples_left - 16'd1;
          if (samples_left == 0) begin
            note_active = 1'b0;
          end
        end
      end
    endfunction

    function void complain(string what);
      errors++;
      if (errors <= 10) begin
        $display("%s", what);
      end
    endfunction

    function void check_sample(out_item_t got);
      out_item_t want;
      if (pending_samples.size() == 0) begin
        complain($sformatf("unexpected sample %0d last=%0b", got.audio_sample,
                           got.last_of_note));
      end else begin
        want = pending_samples.pop_front();
        compared++;
        if (want.last_of_note) begin
          note_ends++;
        end
        if (got.audio_sample !== want.audio_sample ||
            got.last_of_note !== want.last_of_note) begin
          complain($sformatf("sample %0d: expected %0d last=%0b, got %0d last=%0b",
                             compared, want.audio_sample, want.last_of_note,
                             got.audio_sample, got.last_of_note));
        end
      end
    endfunction

    function int unsigned pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  calm = 1'b0;
  logic                  squeeze_req = 1'b0;
  logic                  squeeze_done = 1'b0;
  int unsigned           hold_cycles = 0;
  int unsigned           cycles = 0;
  int unsigned           settings = 1;
  tone_scoreboard        sb;

  byte_tone_synthesizer #(
    .PHASE_BITS(PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, sb.pending());
      $display("byte_tone_synthesizer: mismatch");
      $finish;
    end
  end

  // hold off the output once for a long stretch, otherwise stall at random unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_stall    <= 1'b1;
      hold_cycles  <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 33);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_sample(out_data);
    end
  end

  task automatic send(in_item_t it);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.take_item(it);
  endtask

  task automatic send_fields(cmd_t cmd, logic [BYTE_W-1:0] data_byte);
    in_item_t it;
    it.command   = cmd;
    it.data_byte = data_byte;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] base, logic [31:0] span, logic [15:0] len);
    write_reg(REG_BASE_STEP, base);
    write_reg(REG_RANGE_STEP, span);
    write_reg(REG_NOTE_LENGTH, 32'(len));
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic play_random(int unsigned n_items);
    int unsigned sent;
    int unsigned run;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          send_fields(CMD_LOAD, $urandom_range(0, 1) ? 8'hFF : 8'h00);
        end else begin
          send_fields(CMD_LOAD, 8'($urandom));
        end
        sent++;
        run = (sb.note_length <= 40) ? $urandom_range(0, sb.note_length + 2)
                                     : $urandom_range(0, 40);
        repeat (run) begin
          send_fields(CMD_TICK, 8'($urandom));
          sent++;
        end
      end else begin
        send_fields(cmd_t'($urandom_range(0, 1)), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] len;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_fields(CMD_TICK, 8'hFF);
    send_fields(CMD_LOAD, 8'h00);
    send_fields(CMD_TICK, 8'h00);
    send_fields(CMD_TICK, 8'hFF);
    send_fields(CMD_LOAD, 8'hFF);
    send_fields(CMD_TICK, 8'h5A);
    send_fields(CMD_TICK, 8'hA5);
    send_fields(CMD_LOAD, 8'h80);
    send_fields(CMD_LOAD, 8'h01);
    send_fields(CMD_TICK, 8'h00);
    send_fields(CMD_TICK, 8'h00);
    drain();

    set_config(32'h0, 32'hFFFF_FFFF, 16'd1);
    send_fields(CMD_LOAD, 8'hFF);
    send_fields(CMD_TICK, 8'h00);
    send_fields(CMD_TICK, 8'h00);
    send_fields(CMD_LOAD, 8'h00);
    send_fields(CMD_TICK, 8'hFF);
    drain();

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(CMD_LOAD, 8'hFF);
    send_fields(CMD_TICK, 8'h00);
    send_fields(CMD_TICK, 8'h00);
    send_fields(CMD_TICK, 8'h00);
    drain();

    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    set_config(32'h1234_5678, 32'h0, 16'h0);
    send_fields(CMD_LOAD, 8'h10);
    send_fields(CMD_TICK, 8'h00);
    drain();

    for (int p = 0; p < 10; p++) begin
      calm <= (p == 3);
      if (p == 5) begin
        squeeze_req <= 1'b1;
        len = 16'($urandom_range(60, 200));
      end else begin
        case ($urandom_range(0, 9))
          0: len = 16'h0;
          1: len = 16'hFFFF;
          2: len = 16'($urandom_range(13, 300));
          default: len = 16'($urandom_range(1, 12));
        endcase
      end
      set_config(pick_step(), pick_step(), len);
      play_random(125);
      drain();
    end

    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected samples never arrived", sb.pending());
    end
    $display("run covered %0d loads and %0d ticks over %0d register settings",
             sb.loads, sb.ticks, settings);
    $display("%0d samples compared, %0d of them closing a note, %0d errors",
             sb.compared, sb.note_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("byte_tone_synthesizer: match");
    end else begin
      $display("byte_tone_synthesizer: mismatch");
    end
    $finish;
  end

endmodule

### byte_tone_synthesizer.f
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bts_sine_rom.sv
rtl/core/byte_tone_synthesizer.sv
rtl/core/bts_checker.sv
tb/sv/byte_tone_synthesizer_tb.sv
